>>> hw/rtl/alat_pkg.sv
package alat_pkg;

   localparam int LUX_W = 20;
   localparam logic [LUX_W-1:0] THRESHOLD_RESET = 20'd32;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> hw/rtl/alat_ram.sv
module alat_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 50,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/alat_divider.sv
module alat_divider import alat_pkg::*; #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  div_ctrl_type     ctrl,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output div_stat_type     stat,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    trial;
   logic              fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         rem_in  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (ctrl.start) begin
         den_ff <= divisor;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> hw/rtl/ambient_light_average_threshold.sv
// Moving average of light samples over a ring of WINDOW words, with threshold flag.
// A new word is taken only in idle, once the previous result is in the output register;
//   the serial divider computes one quotient bit per cycle over the running-sum width.
// Reset (synchronous, active high): sum, index and wrap flag clear, threshold = 32.
// The ring needs no clearing: an entry's old value is used only after it was written.
module ambient_light_average_threshold import alat_pkg::*; #(
   parameter int WINDOW = 50
) (
   input  logic             clock,
   input  logic             reset,
   // sample input
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [LUX_W-1:0] req_sample_lux,
   // result output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [LUX_W-1:0] rsp_average_lux,
   output logic             rsp_backlight_on,
   output logic             rsp_window_full,
   // threshold register
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LUX_W-1:0] csr_light_threshold
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = LUX_W + $clog2(WINDOW);

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;  // ring read in flight
   localparam logic [2:0] ST_UPD  = 3'd2;  // sum update, ring write, divider start
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;  // wait for output register

   logic [2:0]       state_ff, state_in;
   logic [LUX_W-1:0] sample_ff;
   logic [IDX_W-1:0] index_ff, index_in;
   logic             wrapped_ff, wrapped_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [LUX_W-1:0] thr_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LUX_W-1:0] avg_ff;
   logic             light_ff;
   logic             full_ff;

   logic             req_accept;
   logic             out_free;
   logic             load_out;
   logic [LUX_W-1:0] old_sample;
   logic [CNT_W-1:0] count;
   logic [SUM_W-1:0] quotient;
   div_ctrl_type     div_ctrl;
   div_stat_type     div_stat;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // output register frees when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_DONE) && out_free;

   alat_ram #(
      .WIDTH (LUX_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPD),
      .wr_addr (index_ff),
      .wr_data (sample_ff),
      .rd_en   (req_accept),
      .rd_addr (index_ff),
      .rd_data (old_sample)
   );

   // ring update: subtract the overwritten word once wrapped
   always_comb begin
      sum_in     = sum_ff;
      index_in   = index_ff;
      wrapped_in = wrapped_ff;
      if (state_ff == ST_UPD) begin
         sum_in = sum_ff - (wrapped_ff ? SUM_W'(old_sample) : '0) + SUM_W'(sample_ff);
         if (index_ff == IDX_W'(WINDOW - 1)) begin
            index_in   = '0;
            wrapped_in = 1'b1;
         end else begin
            index_in = index_ff + IDX_W'(1);
         end
      end
   end

   // filled count after the store; never zero
   assign count = wrapped_in ? CNT_W'(WINDOW) : CNT_W'(index_in);

   assign div_ctrl.start = (state_ff == ST_UPD);

   alat_divider #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (sum_in),
      .divisor  (count),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_UPD;
         ST_UPD:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_light_threshold;
         end
      end
      if (req_accept) begin
         sample_ff <= req_sample_lux;
      end
      if (load_out) begin
         avg_ff   <= quotient[LUX_W-1:0];
         light_ff <= quotient >= SUM_W'(thr_ff);
         full_ff  <= wrapped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_average_lux  = avg_ff;
   assign rsp_backlight_on = light_ff;
   assign rsp_window_full  = full_ff;

`ifndef SYNTHESIS
   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_READ)
      else $error("accepted word did not start a ring read");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("window full flag cleared");

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(avg_ff))
      else $error("stalled result lost or changed");
`endif

endmodule

>>> tb/ambient_light_average_threshold_tb.sv
`timescale 1ns / 100ps

module ambient_light_average_threshold_tb;
   import alat_pkg::*;

   localparam int WINDOW = 50;
   localparam logic [LUX_W-1:0] LUX_MAX = '1;
   // quiet cycles (no handshake of any kind) before the run is declared hung;
   // covers the long receiver hold-off plus a full divide
   localparam int QUIET_LIMIT = 1000;
   // wait out the accept-to-result time plus margin at the end
   localparam int TAIL_CYCLES = 40;
   localparam int NUM_ROWS = 20;

   typedef enum int {
      MIX_WIDE,   // zeros, full scale, small, random, near threshold
      MIX_HIGH,   // almost all full scale, so the window saturates
      MIX_NEAR    // hugs the threshold so the compare hits equality
   } sample_mix_type;

   typedef struct packed {
      logic [LUX_W-1:0] average_lux;
      logic             backlight_on;
      logic             window_full;
   } light_result_type;

   typedef struct packed {
      logic [LUX_W-1:0] sample;
      logic             typed;      // 1: use the literal result below
      light_result_type want;
   } lux_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [LUX_W-1:0] req_sample_lux;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [LUX_W-1:0] rsp_average_lux;
   logic             rsp_backlight_on;
   logic             rsp_window_full;
   logic             csr_valid;
   logic             csr_ready;
   logic [LUX_W-1:0] csr_light_threshold;

   // predictor state: ring of samples, write slot, wrap flag, running sum
   logic [LUX_W-1:0] lux_ring [WINDOW];
   int unsigned      ring_pos = 0;
   bit               ring_full = 1'b0;
   logic [25:0]      lux_sum = '0;
   logic [LUX_W-1:0] light_thr = THRESHOLD_RESET;

   light_result_type pending_means [$];   // results owed by the block, oldest first
   lux_row_type      typed_rows [$];      // directed rows, in drive order
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int               stall_pct = 0;       // receiver stall chance, percent
   int               hold_len = 0;        // cycles of forced receiver hold-off left

   // Directed words. After reset the threshold is 32, so the first three
   // results can be worked out by hand; the rest go through the predictor.
   localparam lux_row_type LUX_ROWS [NUM_ROWS] = '{
      '{20'd32,     1'b1, '{20'd32,     1'b1, 1'b0}},  // equal to threshold
      '{20'd0,      1'b1, '{20'd16,     1'b0, 1'b0}},  // 32/2, below threshold
      '{20'hFFFFF,  1'b1, '{20'd349535, 1'b1, 1'b0}},  // (32+max)/3 truncated
      '{20'hFFFFF,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'hFFFFF,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd0,      1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd1,      1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'hAAAAA,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'h55555,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd31,     1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd32,     1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd33,     1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'h80000,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'h7FFFF,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd0,      1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd0,      1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'hFFFFF,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'd1,      1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'h10000,  1'b0, '{20'd0,      1'b0, 1'b0}},
      '{20'hFFFFE,  1'b0, '{20'd0,      1'b0, 1'b0}}
   };

   ambient_light_average_threshold #(
      .WINDOW (WINDOW)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_lux      (req_sample_lux),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_average_lux     (rsp_average_lux),
      .rsp_backlight_on    (rsp_backlight_on),
      .rsp_window_full     (rsp_window_full),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_light_threshold (csr_light_threshold)
   );

   always #5 clock = ~clock;

   // Store one word in the ring and return the result the block owes for it.
   // Overwritten slot comes off the sum only once the ring has wrapped.
   function automatic light_result_type advance_average(input logic [LUX_W-1:0] s);
      light_result_type r;
      logic [25:0]      fill;
      logic [25:0]      mean;
      if (ring_full) begin
         lux_sum = lux_sum - 26'(lux_ring[ring_pos]);
      end
      lux_sum = lux_sum + 26'(s);
      lux_ring[ring_pos] = s;
      ring_pos++;
      if (ring_pos >= WINDOW) begin
         ring_pos = 0;
         ring_full = 1'b1;
      end
      // filled count never zero here: slot only returns to 0 on a wrap
      fill = ring_full ? 26'(WINDOW) : 26'(ring_pos);
      mean = lux_sum / fill;
      r.average_lux  = mean[LUX_W-1:0];
      r.backlight_on = (mean >= 26'(light_thr));
      r.window_full  = ring_full;
      return r;
   endfunction

   task automatic report_error(input string msg);
      if (mismatch_count < 100) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Monitor: everything sampled at the edge, before the block's own updates.
   always @(posedge clock) begin : monitor
      light_result_type want;
      light_result_type got;
      lux_row_type      row;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            light_thr = csr_light_threshold;
         end
         if (req_valid && !req_stall) begin
            want = advance_average(req_sample_lux);
            // directed words carry their own answer where one was typed in
            if (typed_rows.size() != 0) begin
               row = typed_rows.pop_front();
               if (row.typed) begin
                  want = row.want;
               end
            end
            pending_means.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_average_lux, rsp_backlight_on, rsp_window_full};
            if (pending_means.size() == 0) begin
               report_error($sformatf("result word with none expected: avg %0d",
                                      got.average_lux));
            end else begin
               want = pending_means.pop_front();
               if (got.average_lux !== want.average_lux) begin
                  report_error($sformatf("average_lux %0d, expected %0d",
                                         got.average_lux, want.average_lux));
               end
               if (got.backlight_on !== want.backlight_on) begin
                  report_error($sformatf("backlight_on %b, expected %b (avg %0d)",
                                         got.backlight_on, want.backlight_on, want.average_lux));
               end
               if (got.window_full !== want.window_full) begin
                  report_error($sformatf("window_full %b, expected %b",
                                         got.window_full, want.window_full));
               end
            end
         end
      end
   end

   // Receiver: forced hold-off takes priority, else random stalls.
   always @(posedge clock) begin
      if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog: any handshake counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("ambient_light_average_threshold_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one word; returns in the step of its acceptance with valid still up.
   task automatic drive_sample(input logic [LUX_W-1:0] s, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_sample_lux <= s;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed result is back. One edge first, so
   // a word accepted in the calling step is already counted as owed.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_threshold(input logic [LUX_W-1:0] v);
      csr_valid           <= 1'b1;
      csr_light_threshold <= v;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [LUX_W-1:0] pick_sample(input sample_mix_type mix,
                                                     input logic [LUX_W-1:0] thr);
      int pick;
      int v;
      pick = $urandom_range(99);
      v = int'(thr);
      v = v + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > int'(LUX_MAX)) v = int'(LUX_MAX);
      case (mix)
         MIX_HIGH: begin
            return (pick < 99) ? LUX_MAX : LUX_W'($urandom_range(0, LUX_MAX));
         end
         MIX_NEAR: begin
            return LUX_W'(v);
         end
         default: begin
            if (pick < 25) return LUX_W'($urandom_range(0, LUX_MAX));
            if (pick < 40) return '0;
            if (pick < 55) return LUX_MAX;
            if (pick < 80) return LUX_W'($urandom_range(0, 255));
            return LUX_W'(v);
         end
      endcase
   endfunction

   // One phase: new threshold while idle, then n random words.
   // hold: long receiver hold-off mid-phase so the block backs up into req_stall.
   // pause: sender stops mid-phase until all results are home.
   task automatic run_phase(input logic [LUX_W-1:0] thr, input int send_idle,
                            input int rcv_stall, input int n, input sample_mix_type mix,
                            input bit hold, input bit pause);
      wait_drained();
      write_threshold(thr);
      stall_pct = rcv_stall;
      for (int i = 0; i < n; i++) begin
         if (hold && i == n / 2) begin
            hold_len = 150;
         end
         if (pause && i == n / 2) begin
            wait_drained();
         end
         drive_sample(pick_sample(mix, thr), send_idle);
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_sample_lux      = '0;
      csr_valid           = 1'b0;
      csr_light_threshold = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset threshold, no idling
      for (int i = 0; i < NUM_ROWS; i++) begin
         typed_rows.push_back(LUX_ROWS[i]);
         drive_sample(LUX_ROWS[i].sample, 0);
      end

      // random phases; thresholds sweep both extremes
      run_phase('0,     0,  0,  120, MIX_WIDE, 1'b0, 1'b0);
      run_phase(LUX_MAX, 46, 0,  120, MIX_HIGH, 1'b0, 1'b0);
      run_phase(LUX_W'($urandom_range(0, LUX_MAX)), 0, 46, 150, MIX_WIDE, 1'b1, 1'b0);
      run_phase(LUX_W'($urandom_range(0, 64)), 23, 23, 150, MIX_NEAR, 1'b0, 1'b1);
      run_phase(LUX_W'($urandom_range(0, LUX_MAX)), 0, 46, 150, MIX_NEAR, 1'b0, 1'b0);
      run_phase(THRESHOLD_RESET, 23, 23, 130, MIX_WIDE, 1'b0, 1'b0);
      run_phase(LUX_MAX, 0,  0,  100, MIX_HIGH, 1'b1, 1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_means.size() != 0) begin
         report_error($sformatf("%0d expected results never arrived", pending_means.size()));
      end
      if (mismatch_count == 0) begin
         $display("ambient_light_average_threshold_tb: clean");
      end else begin
         $display("ambient_light_average_threshold_tb: errors");
      end
      $finish;
   end

endmodule

>>> ambient_light_average_threshold.f
hw/rtl/alat_pkg.sv
hw/rtl/alat_ram.sv
hw/rtl/alat_divider.sv
hw/rtl/ambient_light_average_threshold.sv
tb/ambient_light_average_threshold_tb.sv
